>>> src/sgh_pkg.sv
`default_nettype none
package sgh_pkg;

	localparam int DEF_MAX_ROWS = 1024;
	localparam int DEF_MAX_DIMS = 64;
	localparam int DEF_COLUMNS  = 16;
	localparam int LANE_GROUP   = 8;

	localparam logic [23:0] ONE_Q23 = 24'h800000;

	localparam logic [2:0] OP_LOAD_SURPLUS = 3'd0;
	localparam logic [2:0] OP_LOAD_COORD   = 3'd1;
	localparam logic [2:0] OP_BEGIN        = 3'd2;
	localparam logic [2:0] OP_FACTOR       = 3'd3;
	localparam logic [2:0] OP_FINISH       = 3'd4;

	localparam logic [1:0] REG_DIMS  = 2'd0;
	localparam logic [1:0] REG_ROWS  = 2'd1;
	localparam logic [1:0] REG_FIRST = 2'd2;
	localparam logic [1:0] REG_LAST  = 2'd3;

	typedef struct packed {
		logic latch;
		logic wr_surplus;
		logic wr_coord;
		logic start_run;
		logic sweep;
		logic fc_sub;
		logic fac_read;
		logic hat_mul;
		logic w_mul;
		logic w_write;
		logic row_clr;
		logic row_rd;
		logic row_inc;
		logic col_init;
		logic s_rd;
		logic s_mul;
		logic acc_add;
		logic col_inc;
		logic k_clr;
		logic k_inc;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       sweep_last;
		logic       fc_ge_pd;
		logic       row_end;
		logic       w_zero;
		logic       col_last;
		logic       emit_last;
		logic       range_empty;
	} sts_t;

endpackage
`default_nettype wire

>>> src/sgh_in_if.sv
`default_nettype none
interface sgh_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         operation;
	logic [9:0]         row;
	logic [3:0]         column;
	logic [5:0]         dimension;
	logic [23:0]        coordinate;
	logic [7:0]         level;
	logic [7:0]         offset;
	logic signed [31:0] surplus;

	modport source (output valid, operation, row, column, dimension, coordinate, level,
		offset, surplus, input ready);
	modport sink (input valid, operation, row, column, dimension, coordinate, level,
		offset, surplus, output ready);
endinterface
`default_nettype wire

>>> src/sgh_out_if.sv
`default_nettype none
interface sgh_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         column_index;
	logic signed [47:0] value;
	logic               last;

	modport source (output valid, column_index, value, last, input ready);
	modport sink (input valid, column_index, value, last, output ready);
endinterface
`default_nettype wire

>>> src/sparse_grid_hat_interpolation.sv
// Loads write on dispatch; begin clears the run and sweeps all row weights to 1.0.
// Basis factor: reduce a stale count, read coordinate and weight, hat, multiply, write.
// Finish: per active row a weight read, plus a read, multiply and add per column for
// rows of nonzero weight, then one result per cycle while the sink is ready. One item
// is in work at a time. Reset: configuration to defaults, accumulators and factor
// count cleared, then a sweep sets all row weights to 1.0 before any item is taken.
`default_nettype none
module sparse_grid_hat_interpolation #(
	parameter int MAX_ROWS = sgh_pkg::DEF_MAX_ROWS,
	parameter int MAX_DIMS = sgh_pkg::DEF_MAX_DIMS,
	parameter int COLUMNS  = sgh_pkg::DEF_COLUMNS
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire [1:0]  cfg_index,
	input  wire [10:0] cfg_data,
	sgh_in_if.sink     in_ch,
	sgh_out_if.source  out_ch
);
	import sgh_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sgh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	sgh_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_DIMS (MAX_DIMS),
		.COLUMNS  (COLUMNS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.operation    (in_ch.operation),
		.row          (in_ch.row),
		.column       (in_ch.column),
		.dimension    (in_ch.dimension),
		.coordinate   (in_ch.coordinate),
		.level        (in_ch.level),
		.offset       (in_ch.offset),
		.surplus      (in_ch.surplus),
		.cmd          (cmd),
		.sts          (sts),
		.column_index (out_ch.column_index),
		.value        (out_ch.value),
		.last         (out_ch.last)
	);

endmodule
`default_nettype wire

>>> src/sgh_ctrl.sv
`default_nettype none
module sgh_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  wire            out_ready,
	output logic           out_valid,
	input  wire sgh_pkg::sts_t sts,
	output sgh_pkg::cmd_t  cmd
);
	import sgh_pkg::*;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_DISPATCH = 4'd1;
	localparam logic [3:0] ST_SWEEP    = 4'd2;
	localparam logic [3:0] ST_MOD      = 4'd3;
	localparam logic [3:0] ST_F_HAT    = 4'd4;
	localparam logic [3:0] ST_F_MUL    = 4'd5;
	localparam logic [3:0] ST_F_WR     = 4'd6;
	localparam logic [3:0] ST_FIN_ROW  = 4'd7;
	localparam logic [3:0] ST_FIN_W    = 4'd8;
	localparam logic [3:0] ST_FIN_RD   = 4'd9;
	localparam logic [3:0] ST_FIN_MUL  = 4'd10;
	localparam logic [3:0] ST_FIN_ACC  = 4'd11;
	localparam logic [3:0] ST_EMIT     = 4'd12;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.op)
					OP_LOAD_SURPLUS: begin
						cmd.wr_surplus = 1'b1;
						state_d        = ST_IDLE;
					end
					OP_LOAD_COORD: begin
						cmd.wr_coord = 1'b1;
						state_d      = ST_IDLE;
					end
					OP_BEGIN: begin
						cmd.start_run = 1'b1;
						state_d       = ST_SWEEP;
					end
					OP_FACTOR: state_d = ST_MOD;
					OP_FINISH: begin
						if (sts.range_empty) begin
							state_d = ST_IDLE;
						end else begin
							cmd.row_clr = 1'b1;
							state_d     = ST_FIN_ROW;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) state_d = ST_IDLE;
			end
			ST_MOD: begin
				// reduce a stale count after the dimension count shrank
				if (sts.fc_ge_pd) begin
					cmd.fc_sub = 1'b1;
				end else begin
					cmd.fac_read = 1'b1;
					state_d      = ST_F_HAT;
				end
			end
			ST_F_HAT: begin
				cmd.hat_mul = 1'b1;
				state_d     = ST_F_MUL;
			end
			ST_F_MUL: begin
				cmd.w_mul = 1'b1;
				state_d   = ST_F_WR;
			end
			ST_F_WR: begin
				cmd.w_write = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_FIN_ROW: begin
				if (sts.row_end) begin
					cmd.k_clr = 1'b1;
					state_d   = ST_EMIT;
				end else begin
					cmd.row_rd = 1'b1;
					state_d    = ST_FIN_W;
				end
			end
			ST_FIN_W: begin
				if (sts.w_zero) begin
					cmd.row_inc = 1'b1;
					state_d     = ST_FIN_ROW;
				end else begin
					cmd.col_init = 1'b1;
					state_d      = ST_FIN_RD;
				end
			end
			ST_FIN_RD: begin
				cmd.s_rd = 1'b1;
				state_d  = ST_FIN_MUL;
			end
			ST_FIN_MUL: begin
				cmd.s_mul = 1'b1;
				state_d   = ST_FIN_ACC;
			end
			ST_FIN_ACC: begin
				cmd.acc_add = 1'b1;
				if (sts.col_last) begin
					cmd.row_inc = 1'b1;
					state_d     = ST_FIN_ROW;
				end else begin
					cmd.col_inc = 1'b1;
					state_d     = ST_FIN_RD;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.emit_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.k_inc = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while results pending");
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == ST_DISPATCH)
		else $error("accepted transaction not dispatched");
	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && sts.emit_last) |=> state_q == ST_IDLE)
		else $error("run did not end after last result");
	a_sweep_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> !in_ready)
		else $error("input taken during weight sweep");
`endif

endmodule
`default_nettype wire

>>> src/sgh_dp.sv
`default_nettype none
module sgh_dp #(
	parameter int MAX_ROWS = sgh_pkg::DEF_MAX_ROWS,
	parameter int MAX_DIMS = sgh_pkg::DEF_MAX_DIMS,
	parameter int COLUMNS  = sgh_pkg::DEF_COLUMNS
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire  [1:0]         cfg_index,
	input  wire  [10:0]        cfg_data,
	input  wire  [2:0]         operation,
	input  wire  [9:0]         row,
	input  wire  [3:0]         column,
	input  wire  [5:0]         dimension,
	input  wire  [23:0]        coordinate,
	input  wire  [7:0]         level,
	input  wire  [7:0]         offset,
	input  wire  signed [31:0] surplus,
	input  wire sgh_pkg::cmd_t cmd,
	output sgh_pkg::sts_t      sts,
	output logic [3:0]         column_index,
	output logic signed [47:0] value,
	output logic               last
);
	import sgh_pkg::*;

	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int DIW = $clog2(MAX_DIMS);
	localparam int PW  = $clog2(MAX_DIMS + LANE_GROUP) + 1;
	localparam int CW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int AW  = (MAX_ROWS * COLUMNS > 1) ? $clog2(MAX_ROWS * COLUMNS) : 1;
	localparam logic signed [57:0] ACC_MAX = 58'sh7FFFFFFFFFFF;
	localparam logic signed [57:0] ACC_MIN = -ACC_MAX - 58'sd1;

	// configuration
	logic [6:0]  dims_q;
	logic [10:0] rows_q;
	logic [3:0]  first_q, last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q  <= 7'd1;
			rows_q  <= 11'd1;
			first_q <= 4'd0;
			last_q  <= 4'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIMS:  dims_q  <= cfg_data[6:0];
				REG_ROWS:  rows_q  <= cfg_data;
				REG_FIRST: first_q <= cfg_data[3:0];
				REG_LAST:  last_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// latched item
	logic [2:0]         op_q;
	logic [9:0]         row_q;
	logic [3:0]         column_q;
	logic [5:0]         dim_q;
	logic [23:0]        coord_q;
	logic [7:0]         level_q, offset_q;
	logic signed [31:0] surplus_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q      <= operation;
			row_q     <= row;
			column_q  <= column;
			dim_q     <= dimension;
			coord_q   <= coordinate;
			level_q   <= level;
			offset_q  <= offset;
			surplus_q <= surplus;
		end
	end

	// derived limits
	logic [PW-1:0]  dims_c, pd;
	logic [3:0]     last_eff;
	logic [RCW-1:0] nrows;
	logic           row_ok, col_ok, dim_ok;
	logic [RW-1:0]  row_idx;

	always_comb begin
		dims_c = PW'(dims_q);
		if (dims_q == 7'd0) dims_c = PW'(1);
		if (32'(dims_q) > MAX_DIMS) dims_c = PW'(MAX_DIMS);
		pd = ((dims_c + PW'(LANE_GROUP - 1)) >> 3) << 3;
		if (32'(pd) > MAX_DIMS) pd = PW'(MAX_DIMS);
		last_eff = (32'(last_q) > COLUMNS - 1) ? 4'(COLUMNS - 1) : last_q;
		nrows    = (32'(rows_q) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_q);
	end

	assign row_ok  = 32'(row_q) < MAX_ROWS;
	assign col_ok  = 32'(column_q) < COLUMNS;
	assign dim_ok  = 32'(dim_q) < MAX_DIMS;
	assign row_idx = RW'(row_q);

	// counters
	logic [RW-1:0]  sweep_q;
	logic [DIW-1:0] fc_q;
	logic [RCW-1:0] rctr_q;
	logic [CW-1:0]  col_q, k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			fc_q    <= '0;
			rctr_q  <= '0;
			col_q   <= '0;
			k_q     <= '0;
		end else begin
			if (cmd.start_run) sweep_q <= '0;
			else if (cmd.sweep) sweep_q <= sweep_q + RW'(1);
			if (cmd.start_run) fc_q <= '0;
			else if (cmd.fc_sub) fc_q <= DIW'(PW'(fc_q) - pd);
			else if (cmd.w_write) fc_q <= (PW'(fc_q) + PW'(1) == pd) ? '0 : fc_q + DIW'(1);
			if (cmd.row_clr) rctr_q <= '0;
			else if (cmd.row_inc) rctr_q <= rctr_q + RCW'(1);
			if (cmd.col_init) col_q <= CW'(first_q);
			else if (cmd.col_inc) col_q <= col_q + CW'(1);
			if (cmd.k_clr) k_q <= '0;
			else if (cmd.k_inc) k_q <= k_q + CW'(1);
		end
	end

	// coordinate store
	logic [23:0] coord_mem [MAX_DIMS];
	logic [23:0] coord_rd;

	always_ff @(posedge clk) begin
		if (cmd.wr_coord && dim_ok)
			coord_mem[DIW'(dim_q)] <= (coord_q > ONE_Q23) ? ONE_Q23 : coord_q;
		if (cmd.fac_read) coord_rd <= coord_mem[fc_q];
	end

	// row weights
	logic [23:0]   w_mem [MAX_ROWS];
	logic [23:0]   w_rd;
	logic [47:0]   pw_s2;
	logic [23:0]   w_new;
	logic [RW-1:0] w_raddr;

	assign w_new   = 24'((pw_s2 + 48'h400000) >> 23);
	assign w_raddr = cmd.row_rd ? RW'(rctr_q) : row_idx;

	always_ff @(posedge clk) begin
		if (cmd.sweep) w_mem[sweep_q] <= ONE_Q23;
		else if (cmd.w_write && row_ok) w_mem[row_idx] <= w_new;
		if (cmd.row_rd || cmd.fac_read) w_rd <= w_mem[w_raddr];
	end

	// hat factor
	logic signed [32:0] t_s1;
	logic [32:0]        t_abs;
	logic [23:0]        h;

	assign t_abs = t_s1[32] ? 33'(-t_s1) : 33'(t_s1);
	assign h     = (t_abs >= 33'(ONE_Q23)) ? 24'd0 : 24'(33'(ONE_Q23) - t_abs);

	always_ff @(posedge clk) begin
		if (cmd.hat_mul)
			t_s1 <= $signed({1'b0, coord_rd}) * $signed({1'b0, level_q})
				- $signed({2'b00, offset_q, 23'd0});
		if (cmd.w_mul) pw_s2 <= w_rd * h;
	end

	// surplus table
	logic signed [31:0] s_mem [MAX_ROWS * COLUMNS];
	logic signed [31:0] s_rd;
	logic [AW-1:0]      s_waddr, s_raddr;

	assign s_waddr = AW'(32'(row_q) * COLUMNS + 32'(column_q));
	assign s_raddr = AW'(32'(rctr_q) * COLUMNS + 32'(col_q));

	always_ff @(posedge clk) begin
		if (cmd.wr_surplus && row_ok && col_ok) s_mem[s_waddr] <= surplus_q;
		if (cmd.s_rd) s_rd <= s_mem[s_raddr];
	end

	// accumulate
	logic signed [56:0] ps_s1, pr;
	logic signed [57:0] sum;
	logic signed [47:0] acc_q [COLUMNS];
	logic [CW-1:0]      acc_idx;

	assign acc_idx = CW'(col_q - CW'(first_q));
	assign pr      = ps_s1 + 57'sd4194304;
	assign sum     = 58'(acc_q[acc_idx]) + 58'(pr >>> 23);

	always_ff @(posedge clk) begin
		if (cmd.s_mul) ps_s1 <= $signed({1'b0, w_rd}) * s_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COLUMNS; i++) acc_q[i] <= '0;
		end else if (cmd.start_run) begin
			for (int i = 0; i < COLUMNS; i++) acc_q[i] <= '0;
		end else if (cmd.acc_add) begin
			if (sum > ACC_MAX) acc_q[acc_idx] <= 48'(ACC_MAX);
			else if (sum < ACC_MIN) acc_q[acc_idx] <= 48'(ACC_MIN);
			else acc_q[acc_idx] <= 48'(sum);
		end
	end

	// status and results
	always_comb begin
		sts.op          = op_q;
		sts.sweep_last  = 32'(sweep_q) == MAX_ROWS - 1;
		sts.fc_ge_pd    = PW'(fc_q) >= pd;
		sts.row_end     = rctr_q == nrows;
		sts.w_zero      = w_rd == 24'd0;
		sts.col_last    = col_q == CW'(last_eff);
		sts.emit_last   = k_q == CW'(last_eff - first_q);
		sts.range_empty = first_q > last_eff;
	end

	assign column_index = 4'(k_q);
	assign value        = acc_q[k_q];
	assign last         = sts.emit_last;

endmodule
`default_nettype wire

>>> test/sparse_grid_hat_interpolation_test.sv
`timescale 1ns / 1ps
`default_nettype none
module sparse_grid_hat_interpolation_test;
	import sgh_pkg::*;

	localparam int          ROWS_N      = DEF_MAX_ROWS;
	localparam int          DIMS_N      = DEF_MAX_DIMS;
	localparam int          COLS_N      = DEF_COLUMNS;
	localparam logic [2:0]  OP_RESERVED = 3'd5;
	localparam int          SETTLE      = 1100;
	localparam int          STALL_LIMIT = 200000;
	localparam longint      ACC_HI      = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint      ACC_LO      = -ACC_HI - 1;

	typedef struct {
		logic [2:0]         operation;
		logic [9:0]         row;
		logic [3:0]         column;
		logic [5:0]         dimension;
		logic [23:0]        coordinate;
		logic [7:0]         level;
		logic [7:0]         offset;
		logic signed [31:0] surplus;
	} grid_op_t;

	typedef struct {
		logic [3:0]  column_index;
		logic [47:0] value;
		logic        last;
	} column_sum_t;

	typedef struct {
		grid_op_t    op;
		bit          typed;
		logic [47:0] sum;
	} directed_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [10:0] cfg_data;

	sgh_in_if  in_ch();
	sgh_out_if out_ch();

	sparse_grid_hat_interpolation dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	// shadow of the block's state
	logic [6:0]         dims_reg;
	logic [10:0]        rows_reg;
	logic [3:0]         first_reg;
	logic [3:0]         last_reg;
	logic [23:0]        coord_mem [DIMS_N];
	logic [23:0]        weight_mem [ROWS_N];
	logic signed [31:0] surplus_mem [ROWS_N*COLS_N];
	bit                 surplus_set [ROWS_N*COLS_N];
	longint             sums [COLS_N];
	int                 factor_cnt;

	column_sum_t pending_sums [$];
	int          errors;
	int          items_sent;
	int          sums_seen;
	int          finishes;
	bit          quiet;
	int          idle_cycles;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int padded_dims();
		int d;
		d = int'(dims_reg);
		if (d == 0) d = 1;
		if (d > DIMS_N) d = DIMS_N;
		d = ((d + LANE_GROUP - 1) / LANE_GROUP) * LANE_GROUP;
		if (d > DIMS_N) d = DIMS_N;
		return d;
	endfunction

	function automatic int active_rows();
		return (int'(rows_reg) > ROWS_N) ? ROWS_N : int'(rows_reg);
	endfunction

	function automatic longint hat_q23(logic [23:0] x, logic [7:0] lv, logic [7:0] ofs);
		longint t;
		t = longint'(x) * longint'(lv) - (longint'(ofs) << 23);
		if (t < 0) t = -t;
		if (t >= longint'(ONE_Q23)) return 0;
		return longint'(ONE_Q23) - t;
	endfunction

	function automatic longint sat_sum(longint a, longint b);
		longint s;
		s = a + b;
		if (s > ACC_HI) return ACC_HI;
		if (s < ACC_LO) return ACC_LO;
		return s;
	endfunction

	// advance the shadow state and queue the column sums a transaction produces
	task automatic interpolate(input grid_op_t o);
		int     pd;
		int     d;
		int     lst;
		longint p;
		if (o.operation == OP_LOAD_SURPLUS) begin
			surplus_mem[o.row*COLS_N + o.column] = o.surplus;
			surplus_set[o.row*COLS_N + o.column] = 1'b1;
		end else if (o.operation == OP_LOAD_COORD) begin
			coord_mem[o.dimension] = (o.coordinate > ONE_Q23) ? ONE_Q23 : o.coordinate;
		end else if (o.operation == OP_BEGIN) begin
			foreach (weight_mem[r]) weight_mem[r] = ONE_Q23;
			foreach (sums[c]) sums[c] = 0;
			factor_cnt = 0;
		end else if (o.operation == OP_FACTOR) begin
			pd = padded_dims();
			d = factor_cnt % pd;
			p = longint'(weight_mem[o.row]) * hat_q23(coord_mem[d], o.level, o.offset)
				+ (64'sd1 <<< 22);
			weight_mem[o.row] = p[46:23];
			factor_cnt = (d + 1) % pd;
		end else if (o.operation == OP_FINISH) begin
			lst = int'(last_reg);
			if (first_reg <= lst) begin
				for (int r = 0; r < active_rows(); r++) begin
					if (weight_mem[r] != 0) begin
						for (int c = first_reg; c <= lst; c++) begin
							p = longint'(weight_mem[r]) * longint'(surplus_mem[r*COLS_N + c])
								+ (64'sd1 <<< 22);
							sums[c - first_reg] = sat_sum(sums[c - first_reg], p >>> 23);
						end
					end
				end
				for (int k = 0; k <= lst - first_reg; k++)
					pending_sums.push_back('{k[3:0], sums[k][47:0], k == lst - first_reg});
			end
		end
	endtask

	task automatic send_op(input grid_op_t o);
		if (!quiet && $urandom_range(4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.operation  <= o.operation;
		in_ch.row        <= o.row;
		in_ch.column     <= o.column;
		in_ch.dimension  <= o.dimension;
		in_ch.coordinate <= o.coordinate;
		in_ch.level      <= o.level;
		in_ch.offset     <= o.offset;
		in_ch.surplus    <= o.surplus;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
		if (o.operation == OP_FINISH) finishes++;
	endtask

	task automatic run_op(input grid_op_t o);
		send_op(o);
		interpolate(o);
	endtask

	function automatic grid_op_t make_op(logic [2:0] opc);
		grid_op_t o;
		o.operation  = opc;
		o.row        = 10'($urandom_range(ROWS_N - 1));
		o.column     = 4'($urandom_range(COLS_N - 1));
		o.dimension  = 6'($urandom_range(DIMS_N - 1));
		o.coordinate = 24'($urandom());
		o.level      = 8'($urandom());
		o.offset     = 8'($urandom());
		o.surplus    = $urandom();
		return o;
	endfunction

	// load any surplus entry the next finish would read before it was written
	task automatic fill_surplus();
		grid_op_t o;
		for (int r = 0; r < active_rows(); r++)
			for (int c = first_reg; c <= last_reg; c++)
				if (!surplus_set[r*COLS_N + c]) begin
					o = make_op(OP_LOAD_SURPLUS);
					o.row = 10'(r);
					o.column = 4'(c);
					run_op(o);
				end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DIMS:  dims_reg  = val[6:0];
			REG_ROWS:  rows_reg  = val;
			REG_FIRST: first_reg = val[3:0];
			REG_LAST:  last_reg  = val[3:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_phase(input int n);
		grid_op_t o;
		int       sent0;
		int       pick;
		int       nr;
		int       d;
		sent0 = items_sent;
		while (items_sent - sent0 < n) begin
			pick = $urandom_range(9);
			nr = active_rows();
			if (pick <= 5) begin
				if ($urandom_range(3) != 0) run_op(make_op(OP_BEGIN));
				repeat ($urandom_range(1, 12)) begin
					o = make_op(OP_FACTOR);
					if (nr > 0 && $urandom_range(3) != 0) o.row = 10'($urandom_range(nr - 1));
					// aim the offset near x*level so most hats are nonzero
					d = factor_cnt % padded_dims();
					if ($urandom_range(4) != 0)
						o.offset = 8'((longint'(coord_mem[d]) * o.level) >> 23)
							+ 8'($urandom_range(1));
					run_op(o);
				end
				fill_surplus();
				run_op(make_op(OP_FINISH));
			end else if (pick == 6) begin
				run_op(make_op(OP_LOAD_SURPLUS));
			end else if (pick == 7) begin
				run_op(make_op(OP_LOAD_COORD));
			end else if (pick == 8) begin
				send_op(make_op(OP_RESERVED + 3'($urandom_range(2))));
				items_sent--;
			end else begin
				fill_surplus();
				run_op(make_op(OP_FINISH));
			end
		end
	endtask

	function automatic directed_row_t drow(logic [2:0] opc, logic [9:0] r, logic [3:0] c,
		logic [5:0] dm, logic [23:0] x, logic [7:0] lv, logic [7:0] ofs,
		logic [31:0] s, bit typed, logic [47:0] sum);
		directed_row_t t;
		t.op = '{opc, r, c, dm, x, lv, ofs, s};
		t.typed = typed;
		t.sum = sum;
		return t;
	endfunction

	directed_row_t directed [$];

	initial begin
		grid_op_t o;
		errors = 0;
		items_sent = 0;
		sums_seen = 0;
		finishes = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DIMS;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.operation = OP_BEGIN;
		in_ch.row = '0;
		in_ch.column = '0;
		in_ch.dimension = '0;
		in_ch.coordinate = '0;
		in_ch.level = '0;
		in_ch.offset = '0;
		in_ch.surplus = '0;
		dims_reg = 7'd1;
		rows_reg = 11'd1;
		first_reg = '0;
		last_reg = '0;
		foreach (coord_mem[i]) coord_mem[i] = '0;
		foreach (surplus_mem[i]) begin
			surplus_mem[i] = '0;
			surplus_set[i] = 1'b0;
		end
		interpolate(make_op(OP_BEGIN));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE) @(posedge clk);

		// every coordinate is written before any factor reads it
		for (int i = 0; i < DIMS_N; i++) begin
			o = make_op(OP_LOAD_COORD);
			o.dimension = 6'(i);
			run_op(o);
		end

		directed.push_back(drow(OP_LOAD_SURPLUS, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0));
		directed.push_back(drow(OP_FINISH, 0, 0, 0, 0, 0, 0, 0, 1, 48'h0000_7FFF_FFFF));
		// finish again without begin: the sum doubles
		directed.push_back(drow(OP_FINISH, 0, 0, 0, 0, 0, 0, 0, 1, 48'h0000_FFFF_FFFE));
		directed.push_back(drow(OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(drow(OP_LOAD_SURPLUS, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 0, 0));
		directed.push_back(drow(OP_FINISH, 0, 0, 0, 0, 0, 0, 0, 1, 48'hFFFF_8000_0000));
		directed.push_back(drow(OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(drow(OP_LOAD_COORD, 0, 0, 0, 24'hFF_FFFF, 0, 0, 0, 0, 0));
		directed.push_back(drow(OP_LOAD_COORD, 0, 0, 63, 24'h00_0000, 0, 0, 0, 0, 0));
		directed.push_back(drow(OP_LOAD_COORD, 0, 0, 1, 24'h80_0001, 0, 0, 0, 0, 0));
		directed.push_back(drow(OP_FACTOR, 0, 0, 0, 0, 1, 1, 0, 0, 0));
		directed.push_back(drow(OP_FACTOR, 1023, 0, 0, 0, 255, 255, 0, 0, 0));
		directed.push_back(drow(OP_FACTOR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(drow(OP_LOAD_SURPLUS, 1023, 15, 0, 0, 0, 0, 32'h0123_4567, 0, 0));
		directed.push_back(drow(OP_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(drow(OP_RESERVED, 10'h3FF, 4'hF, 6'h3F, 24'hFF_FFFF,
			8'hFF, 8'hFF, 32'hFFFF_FFFF, 0, 0));
		directed.push_back(drow(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// a zero hat clears the row weight, so finish skips the row
		directed.push_back(drow(OP_FACTOR, 0, 0, 0, 0, 0, 255, 0, 0, 0));
		directed.push_back(drow(OP_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(drow(OP_FACTOR, 5, 0, 0, 0, 3, 1, 0, 0, 0));
		directed.push_back(drow(OP_FACTOR, 512, 0, 0, 0, 128, 64, 0, 0, 0));

		foreach (directed[i]) begin
			o = directed[i].op;
			if (o.operation >= OP_RESERVED) begin
				send_op(o);
				items_sent--;
			end else if (directed[i].typed) begin
				send_op(o);
				interpolate(o);
				void'(pending_sums.pop_back());
				pending_sums.push_back('{4'd0, directed[i].sum, 1'b1});
			end else begin
				run_op(o);
			end
		end
		drain();

		// every active row of one column
		write_reg(REG_DIMS, 11'd64);
		write_reg(REG_ROWS, 11'd12);
		write_reg(REG_FIRST, 11'd15);
		write_reg(REG_LAST, 11'd15);
		random_phase(15);
		drain();

		write_reg(REG_DIMS, 11'd0);
		write_reg(REG_ROWS, 11'd0);
		write_reg(REG_FIRST, 11'd0);
		write_reg(REG_LAST, 11'd15);
		random_phase(20);
		drain();

		write_reg(REG_DIMS, 11'd127);
		write_reg(REG_ROWS, 11'd6);
		write_reg(REG_FIRST, 11'd3);
		write_reg(REG_LAST, 11'd9);
		random_phase(25);
		drain();

		// shrink the dimension count under a large factor count; row count above the
		// store size with an empty column range
		write_reg(REG_DIMS, 11'd9);
		write_reg(REG_ROWS, 11'd2047);
		write_reg(REG_FIRST, 11'd10);
		write_reg(REG_LAST, 11'd4);
		random_phase(20);
		drain();

		write_reg(REG_DIMS, 11'd7);
		write_reg(REG_ROWS, 11'd4);
		write_reg(REG_FIRST, 11'd0);
		write_reg(REG_LAST, 11'd15);
		random_phase(20);
		quiet = 1'b1;
		random_phase(15);
		drain();

		$display("Sent %0d transactions (%0d finishes), checked %0d column sums", items_sent,
			finishes, sums_seen);
		$display("Register sweep covered dims 0..127, rows 0..2047 and empty column ranges");
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// receiver stalls in short random bursts
	int stall_left;
	initial stall_left = 0;
	initial out_ch.ready = 1'b0;
	always @(posedge clk) begin
		logic rdy;
		rdy = 1'b1;
		if (stall_left > 0) begin
			stall_left--;
			rdy = 1'b0;
		end else if (!quiet && $urandom_range(5) == 0) begin
			stall_left = $urandom_range(0, 2);
			rdy = 1'b0;
		end
		out_ch.ready <= rdy;
	end

	always @(posedge clk) begin
		column_sum_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			sums_seen++;
			if (pending_sums.size() == 0) begin
				$error("unexpected result: column_index %0d value %h", out_ch.column_index,
					out_ch.value);
				errors++;
			end else begin
				e = pending_sums.pop_front();
				if (out_ch.column_index !== e.column_index) begin
					$error("column_index: expected %0d, got %0d", e.column_index,
						out_ch.column_index);
					errors++;
				end
				if (out_ch.value !== e.value) begin
					$error("value: expected %h, got %h", e.value, out_ch.value);
					errors++;
				end
				if (out_ch.last !== e.last) begin
					$error("last: expected %b, got %b", e.last, out_ch.last);
					errors++;
				end
			end
		end
	end

	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles = 0;
		end else if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

endmodule
`default_nettype wire

>>> filelist.f
src/sgh_pkg.sv
src/sgh_in_if.sv
src/sgh_out_if.sv
src/sgh_ctrl.sv
src/sgh_dp.sv
src/sparse_grid_hat_interpolation.sv
test/sparse_grid_hat_interpolation_test.sv
